// ===== design/quicksort_argsort_assert.svh =====
// Assertion macros for the quicksort_argsort checker.
`ifndef QUICKSORT_ARGSORT_ASSERT_SVH
`define QUICKSORT_ARGSORT_ASSERT_SVH

// ante true at one edge implies cons at the next edge
`define QSA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("quicksort_argsort assertion failed");

// expr never true at any edge
`define QSA_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("quicksort_argsort assertion failed");

`endif

// ===== design/qsa_pkg.sv =====
// ----------------------------------------------------------------------------
// qsa_pkg
// Types and constants shared by the quicksort argsort block.
// ----------------------------------------------------------------------------
package qsa_pkg;

    localparam int QSA_CAPACITY = 64;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 6;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sample_value;
        logic                      final_item;
    } sample_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic [POS_W-1:0]          source_position;
        logic                      end_of_run;
        logic                      overflow_flag;
    } result_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          pos;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic load_wr;
        logic sort_init;
        logic pop_rd;
        logic range_ld;
        logic pivot_ld;
        logic scan_rd;
        logic scan_ld;
        logic step;
        logic fill_rd;
        logic xa;
        logic xb;
        logic push_hi;
        logic push_lo;
        logic out_rd;
        logic out_ld;
        logic out_next;
        logic clear;
    } qsa_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic sp_zero;
        logic range_ok;
        logic le_pivot;
        logic j_at_hi;
        logic need_hi;
        logic need_lo;
        logic few;
        logic k_last;
        logic out_taken;
    } qsa_stat_t;

endpackage

// ===== design/qsa_dp.sv =====
// ----------------------------------------------------------------------------
// qsa_dp
// Datapath: value/tag store, range stack, scan indices and output register.
// ----------------------------------------------------------------------------
module qsa_dp
    import qsa_pkg::*;
#(
    parameter int CAPACITY = QSA_CAPACITY
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  sample_t   sample,
    input  qsa_cmd_t  cmd,
    output qsa_stat_t stat,
    output result_t   result,
    output logic      result_valid,
    input  logic      result_ready
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = AW + 1;

    entry_t          mem [CAPACITY];
    logic [2*AW-1:0] stk [CAPACITY];

    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             sp_reg;
    logic                      dropped_reg;
    logic [AW-1:0]             lo_reg, hi_reg, j_reg, fill_reg, k_reg;
    logic signed [VALUE_W-1:0] pivot_reg;
    entry_t                    cur_reg, tmp_reg, rd_reg;
    logic [2*AW-1:0]           stk_rd_reg;
    result_t                   result_reg;
    logic                      result_valid_reg;

    logic          full;
    logic [CW-1:0] sp_dec;
    logic [AW-1:0] stk_lo, stk_hi;
    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    entry_t        wr_data;

    assign full   = (count_reg == CW'(CAPACITY));
    assign sp_dec = sp_reg - CW'(1);
    assign stk_lo = stk_rd_reg[2*AW-1:AW];
    assign stk_hi = stk_rd_reg[AW-1:0];

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = j_reg;
        wr_data = tmp_reg;
        if (cmd.load_wr && !full)
        begin
            wr_en         = 1'b1;
            wr_addr       = count_reg[AW-1:0];
            wr_data.value = sample.sample_value;
            wr_data.pos   = POS_W'(count_reg);
        end
        else if (cmd.xa)
        begin
            wr_en   = 1'b1;
            wr_addr = fill_reg;
            wr_data = cur_reg;
        end
        else if (cmd.xb)
        begin
            wr_en = 1'b1;
        end
    end

    always_comb
    begin
        if (cmd.fill_rd)
            rd_addr = fill_reg;
        else if (cmd.out_rd)
            rd_addr = k_reg;
        else if (cmd.range_ld)
            rd_addr = stk_hi;
        else
            rd_addr = j_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_reg <= mem[rd_addr];
        if (cmd.sort_init)
            stk[0] <= {AW'(0), AW'(count_reg - CW'(1))};
        else if (cmd.push_hi)
            stk[sp_reg[AW-1:0]] <= {fill_reg + AW'(1), hi_reg};
        else if (cmd.push_lo)
            stk[sp_reg[AW-1:0]] <= {lo_reg, fill_reg - AW'(1)};
        stk_rd_reg <= stk[sp_dec[AW-1:0]];
    end

    // scan payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.range_ld)
        begin
            lo_reg <= stk_lo;
            hi_reg <= stk_hi;
        end
        if (cmd.pivot_ld)
            pivot_reg <= rd_reg.value;
        if (cmd.scan_ld)
            cur_reg <= rd_reg;
        if (cmd.xa)
            tmp_reg <= rd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            sp_reg           <= '0;
            dropped_reg      <= 1'b0;
            j_reg            <= '0;
            fill_reg         <= '0;
            k_reg            <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (cmd.load_wr)
            begin
                if (full)
                    dropped_reg <= 1'b1;
                else
                    count_reg <= count_reg + CW'(1);
            end
            if (cmd.sort_init)
                sp_reg <= CW'(1);
            else if (cmd.pop_rd)
                sp_reg <= sp_dec;
            else if (cmd.push_hi || cmd.push_lo)
                sp_reg <= sp_reg + CW'(1);
            if (cmd.pivot_ld)
            begin
                j_reg    <= lo_reg;
                fill_reg <= lo_reg;
            end
            else if (cmd.step)
                j_reg <= j_reg + AW'(1);
            else if (cmd.xb && (j_reg != hi_reg))
            begin
                j_reg    <= j_reg + AW'(1);
                fill_reg <= fill_reg + AW'(1);
            end
            if (cmd.out_ld)
            begin
                result_valid_reg           <= 1'b1;
                result_reg.sorted_value    <= rd_reg.value;
                result_reg.source_position <= rd_reg.pos;
                result_reg.end_of_run      <= stat.k_last;
                result_reg.overflow_flag   <= dropped_reg;
            end
            else if (result_ready)
                result_valid_reg <= 1'b0;
            if (cmd.out_next)
                k_reg <= k_reg + AW'(1);
            if (cmd.clear)
            begin
                count_reg   <= '0;
                sp_reg      <= '0;
                dropped_reg <= 1'b0;
                k_reg       <= '0;
            end
        end
    end

    always_comb
    begin
        stat.sp_zero   = (sp_reg == '0);
        stat.range_ok  = (stk_lo < stk_hi);
        stat.le_pivot  = (rd_reg.value <= pivot_reg);
        stat.j_at_hi   = (j_reg == hi_reg);
        stat.need_hi   = ((XW'(fill_reg) + XW'(1)) < XW'(hi_reg));
        stat.need_lo   = (XW'(fill_reg) > (XW'(lo_reg) + XW'(1)));
        stat.few       = (count_reg < CW'(2));
        stat.k_last    = ((CW'(k_reg) + CW'(1)) == count_reg);
        stat.out_taken = result_valid_reg && result_ready;
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

// ===== design/qsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// qsa_ctrl
// Sequencer: load, range stack pop, Lomuto scan with swaps, pushes, drain.
// ----------------------------------------------------------------------------
module qsa_ctrl
    import qsa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      sample_valid,
    input  logic      final_item,
    output logic      sample_ready,
    input  qsa_stat_t stat,
    output qsa_cmd_t  cmd
);

    typedef enum logic [13:0] {
        S_LOAD  = 14'b00000000000001,
        S_INIT  = 14'b00000000000010,
        S_POP   = 14'b00000000000100,
        S_POPW  = 14'b00000000001000,
        S_PIV   = 14'b00000000010000,
        S_SCAN  = 14'b00000000100000,
        S_SCANW = 14'b00000001000000,
        S_XA    = 14'b00000010000000,
        S_XB    = 14'b00000100000000,
        S_PUSHH = 14'b00001000000000,
        S_PUSHL = 14'b00010000000000,
        S_ORD   = 14'b00100000000000,
        S_OLD   = 14'b01000000000000,
        S_OWAIT = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_LOAD;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        sample_ready = 1'b0;
        case (state_reg)
            S_LOAD:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.load_wr = 1'b1;
                    if (final_item)
                        state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                if (stat.few)
                    state_next = S_ORD;
                else
                begin
                    cmd.sort_init = 1'b1;
                    state_next    = S_POP;
                end
            end
            S_POP:
            begin
                if (stat.sp_zero)
                    state_next = S_ORD;
                else
                begin
                    cmd.pop_rd = 1'b1;
                    state_next = S_POPW;
                end
            end
            S_POPW:
            begin
                cmd.range_ld = 1'b1;
                state_next   = stat.range_ok ? S_PIV : S_POP;
            end
            S_PIV:
            begin
                cmd.pivot_ld = 1'b1;
                state_next   = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = S_SCANW;
            end
            S_SCANW:
            begin
                cmd.scan_ld = 1'b1;
                // the pivot word itself always passes, so the final swap lands here
                if (stat.le_pivot)
                begin
                    cmd.fill_rd = 1'b1;
                    state_next  = S_XA;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_XA:
            begin
                cmd.xa     = 1'b1;
                state_next = S_XB;
            end
            S_XB:
            begin
                cmd.xb     = 1'b1;
                state_next = stat.j_at_hi ? S_PUSHH : S_SCAN;
            end
            S_PUSHH:
            begin
                cmd.push_hi = stat.need_hi;
                state_next  = S_PUSHL;
            end
            S_PUSHL:
            begin
                cmd.push_lo = stat.need_lo;
                state_next  = S_POP;
            end
            S_ORD:
            begin
                cmd.out_rd = 1'b1;
                state_next = S_OLD;
            end
            S_OLD:
            begin
                cmd.out_ld = 1'b1;
                state_next = S_OWAIT;
            end
            S_OWAIT:
            begin
                if (stat.out_taken)
                begin
                    if (stat.k_last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        cmd.out_next = 1'b1;
                        state_next   = S_ORD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

// ===== design/quicksort_argsort.sv =====
// Load: one word per cycle while collecting the set.
// Sort: pop a range, load its pivot, read and compare each element, swap passers, push.
// Drain: each word is read, registered, held until taken; next set loads after the last.
// Store and range stack are single-write memories, so a swap writes in two states.
// Reset (rst_n, async low) clears counts, stack pointer, drop flag and output valid.
// ----------------------------------------------------------------------------
// quicksort_argsort
// Argsort of signed 32-bit words by in-place Lomuto quicksort with range stack.
// ----------------------------------------------------------------------------
module quicksort_argsort
    import qsa_pkg::*;
#(
    parameter int CAPACITY = QSA_CAPACITY
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    sample_valid,
    output logic    sample_ready,
    input  sample_t sample,
    output logic    result_valid,
    input  logic    result_ready,
    output result_t result
);

    qsa_cmd_t  cmd;
    qsa_stat_t stat;

    qsa_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .final_item   (sample.final_item),
        .sample_ready (sample_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    qsa_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .cmd          (cmd),
        .stat         (stat),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule

// ===== design/qsa_checker.sv =====
// ----------------------------------------------------------------------------
// qsa_checker
// Port-level checks on the quicksort argsort block, bound to the top level.
// ----------------------------------------------------------------------------
`include "quicksort_argsort_assert.svh"

module qsa_checker
    import qsa_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    sample_valid,
    input logic    sample_ready,
    input sample_t sample,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result
);

    // loading and draining never overlap
    `QSA_ASSERT_NEVER(a_no_overlap, sample_ready && result_valid)
    `QSA_ASSERT_NEXT(a_out_hold, result_valid && !result_ready, result_valid && $stable(result))
    // a final word closes the load window
    `QSA_ASSERT_NEXT(a_final_stops, sample_valid && sample_ready && sample.final_item, !sample_ready)
    `QSA_ASSERT_NEXT(a_run_reopens, result_valid && result_ready && result.end_of_run, sample_ready)

endmodule

bind quicksort_argsort qsa_checker u_qsa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
